### design/assert_macros.svh
// Assertion shorthands for the RTL. Every check is sampled on the
// rising edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BOFU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication.
`define BOFU_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/bofu_pkg.sv
`default_nettype none

package bofu_pkg;

  localparam int PHYS_ADDR_BITS_DEF = 21;
  localparam int CFG_ADDR_BITS      = 5;
  localparam int CFG_DATA_BITS      = 32;

  // Register offsets, in units of 32-bit words.
  typedef enum logic [2:0] {
    REG_BURST_EN   = 3'd0,
    REG_SKIP_EN    = 3'd1,
    REG_BANK_MODES = 3'd2,
    REG_SEG0       = 3'd3,
    REG_SEG1       = 3'd4,
    REG_SEG2       = 3'd5,
    REG_SEG3       = 3'd6
  } reg_idx_t;

  localparam logic [1:0] BANK_MODE_BURST = 2'd1;
  localparam logic [7:0] OPC_JSR         = 8'h20;
  localparam logic [2:0] OPS_TWO         = 3'd2;

  typedef struct packed {
    logic            burst_enable;
    logic            skip_cycle_enable;
    logic [7:0]      bank_modes;
    logic [3:0][7:0] segment;
  } cfg_t;

  // Per-opcode attributes: bit 7 skips the operand cycle in a plain fetch,
  // bit 6 breaks the burst, bits 2..0 give the operand count.
  localparam logic [7:0] OP_INFO [256] = '{
    8'o310, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o310, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o310, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o310, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o310, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o310, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o310, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132
  };

  // Little-endian byte lane of a 32-bit word.
  function automatic logic [7:0] byte_sel(input logic [31:0] word, input logic [1:0] idx);
    logic [31:0] shifted;
    shifted  = word >> {idx, 3'b000};
    byte_sel = shifted[7:0];
  endfunction

endpackage

`default_nettype wire

### design/bofu_cfg.sv
`default_nettype none

module bofu_cfg (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [bofu_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire  [bofu_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [bofu_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready,
  output bofu_pkg::cfg_t                      cfg
);
  import bofu_pkg::*;

  logic     wr_en;
  reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BURST_EN:   cfg.burst_enable      <= pwdata[0];
        REG_SKIP_EN:    cfg.skip_cycle_enable <= pwdata[0];
        REG_BANK_MODES: cfg.bank_modes        <= pwdata[7:0];
        REG_SEG0:       cfg.segment[0]        <= pwdata[7:0];
        REG_SEG1:       cfg.segment[1]        <= pwdata[7:0];
        REG_SEG2:       cfg.segment[2]        <= pwdata[7:0];
        REG_SEG3:       cfg.segment[3]        <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_BURST_EN:   prdata[0]   = cfg.burst_enable;
      REG_SKIP_EN:    prdata[0]   = cfg.skip_cycle_enable;
      REG_BANK_MODES: prdata[7:0] = cfg.bank_modes;
      REG_SEG0:       prdata[7:0] = cfg.segment[0];
      REG_SEG1:       prdata[7:0] = cfg.segment[1];
      REG_SEG2:       prdata[7:0] = cfg.segment[2];
      REG_SEG3:       prdata[7:0] = cfg.segment[3];
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### design/burst_opcode_fetch_unit.sv
`default_nettype none
// Channel   Dir  Contents
// s_axis    in   fetch_pc, line_word_a, line_word_b
// m_axis    out  opcode_byte, operand_low, operand_high, cycles_used, mapped_pc
// apb       in   burst_enable, skip_cycle_enable, bank_modes, segment_0..3
//
// Two register stages: an input register and a result register. A fetch
// moves from the input register into the result register, which drives
// m_tvalid. One fetch can be accepted every cycle while the result is not
// stalled. The line cache and burst-break flag update when a fetch moves
// into the result register. Reset clears the control state, the line
// cache and all config registers. A stalled result holds the result
// register; the input register still takes a new fetch only when empty.

module burst_opcode_fetch_unit #(
  parameter int PHYS_ADDR_BITS = bofu_pkg::PHYS_ADDR_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // [15:0] fetch_pc, [47:16] line_word_a, [79:48] line_word_b
  input  wire  [79:0]                         s_tdata,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // [7:0] opcode_byte, [15:8] operand_low, [23:16] operand_high,
  // [25:24] cycles_used, [46:26] mapped_pc, [47] zero
  output logic [47:0]                         m_tdata,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [bofu_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  wire  [bofu_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [bofu_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import bofu_pkg::*;

  localparam int         MAP_BITS = (PHYS_ADDR_BITS < 21) ? PHYS_ADDR_BITS : 21;
  localparam logic [20:0] MAP_MASK = 21'((64'(1) << MAP_BITS) - 64'(1));

  cfg_t cfg;

  bofu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register.
  logic        s1_valid;
  logic [15:0] s1_pc;
  logic [31:0] s1_wa;
  logic [31:0] s1_wb;

  // Line cache state. The cached address is word aligned, so only 14 bits.
  logic [31:0] cached_line;
  logic [13:0] cached_addr;
  logic        broken;

  logic load_in;
  logic advance;

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign load_in  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      s1_pc <= s_tdata[15:0];
      s1_wa <= s_tdata[47:16];
      s1_wb <= s_tdata[79:48];
    end
  end

  // Fetch decode.
  logic [1:0]  bank;
  logic [1:0]  mode;
  logic        burst_sel;
  logic [1:0]  idx;
  logic [13:0] line_addr;
  logic        refill;
  logic [31:0] line_data;
  logic [7:0]  b_op;
  logic [7:0]  b_info;
  logic        need_lo;
  logic        need_hi;
  logic        crossed;
  logic [7:0]  b_lo;
  logic [7:0]  b_hi;
  logic [1:0]  b_cyc;
  logic [47:0] window;
  logic [47:0] p_shift;
  logic [7:0]  p_op;
  logic [7:0]  p_info;
  logic        p_skip;
  logic        p_three;
  logic [1:0]  p_cyc;
  logic [7:0]  seg;
  logic [21:0] phys_full;
  logic [7:0]  op_out;
  logic [7:0]  lo_out;
  logic [7:0]  hi_out;
  logic [1:0]  cyc_out;
  logic [20:0] mapped_out;

  always_comb begin
    bank      = s1_pc[15:14];
    mode      = 2'(cfg.bank_modes >> {bank, 1'b0});
    burst_sel = cfg.burst_enable && (mode == BANK_MODE_BURST);
    idx       = s1_pc[1:0];
    line_addr = s1_pc[15:2];

    // Burst path: serve from the cached word, refilling from the fetched
    // word when the line changed or the previous fetch broke the burst.
    refill    = (line_addr != cached_addr) || broken;
    line_data = refill ? s1_wa : cached_line;
    b_op      = byte_sel(line_data, idx);
    b_info    = OP_INFO[b_op];
    need_lo   = b_info[2:0] != 3'd0;
    need_hi   = b_info[2:0] >= OPS_TWO;
    b_lo      = need_lo ? ((idx == 2'd3) ? s1_wb[7:0] : byte_sel(line_data, idx + 2'd1))
                        : 8'h00;
    b_hi      = need_hi ? (idx[1] ? byte_sel(s1_wb, {1'b0, idx[0]})
                                  : byte_sel(line_data, idx + 2'd2))
                        : 8'h00;
    // An operand past the end of the cached word pulls in the next word.
    crossed   = (need_lo && (idx == 2'd3)) || (need_hi && idx[1]);
    b_cyc     = 2'(refill) + 2'(crossed);

    // Plain path: bytes straight from the two words.
    window    = {s1_wb[15:0], s1_wa};
    p_shift   = window >> {idx, 3'b000};
    p_op      = p_shift[7:0];
    p_info    = OP_INFO[p_op];
    p_skip    = p_info[7] && cfg.skip_cycle_enable;
    p_three   = (p_info[2:0] == OPS_TWO) || (p_op == OPC_JSR);
    p_cyc     = 2'd1 + 2'(!p_skip) + 2'(p_three);

    seg        = cfg.segment[bank];
    phys_full  = {seg, s1_pc[13:0]};
    mapped_out = phys_full[20:0] & MAP_MASK;

    if (burst_sel) begin
      op_out  = b_op;
      lo_out  = b_lo;
      hi_out  = b_hi;
      cyc_out = b_cyc;
    end else begin
      op_out  = p_op;
      lo_out  = p_shift[15:8];
      hi_out  = p_three ? p_shift[23:16] : 8'h00;
      cyc_out = p_cyc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cached_line <= '0;
      cached_addr <= '0;
      broken      <= 1'b0;
    end else if (advance) begin
      if (burst_sel) begin
        cached_line <= crossed ? s1_wb : line_data;
        cached_addr <= crossed ? line_addr + 14'd1 : line_addr;
        broken      <= b_info[6];
      end else begin
        broken      <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {1'b0, mapped_out, cyc_out, hi_out, lo_out, op_out};
    end
  end

`include "assert_macros.svh"

  `BOFU_ASSERT_NXT(a_plain_breaks, advance && !burst_sel, broken)
  `BOFU_ASSERT_NXT(a_plain_keeps_line, advance && !burst_sel, $stable(cached_line))
  `BOFU_ASSERT_IMP(a_burst_cyc_max, advance && burst_sel, cyc_out != 2'd3)
  `BOFU_ASSERT_NXT(a_addr_follows, advance && burst_sel && !crossed,
                   cached_addr == $past(line_addr))

endmodule

`default_nettype wire

### tb/fetch_checker.sv
`timescale 1ns / 100ps

// Watches the fetch stream, the result stream and the register port.
// Every accepted fetch is run through a local model of the unit and the
// expected result is queued until the matching result transaction comes out.
module fetch_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [79:0]                         s_tdata,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [47:0]                         m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bofu_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [bofu_pkg::CFG_DATA_BITS-1:0]  pwdata,
  input  logic                                pready,
  output int                                  mismatches,
  output int                                  in_flight
);
  import bofu_pkg::*;

  typedef struct packed {
    logic [7:0]  opcode;
    logic [7:0]  operand_lo;
    logic [7:0]  operand_hi;
    logic [1:0]  cycles;
    logic [20:0] phys_pc;
  } fetch_result_t;

  // Opcode attributes: bit 7 skips the operand cycle in a plain fetch,
  // bit 6 breaks the burst, bits 2..0 give the operand count.
  localparam logic [7:0] OPCODE_ATTR [256] = '{
    8'o310, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o310, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o310, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o310, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o310, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o310, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o310, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o021, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o021, 8'o210, 8'o021, 8'o132, 8'o132, 8'o132, 8'o132,
    8'o021, 8'o121, 8'o100, 8'o121, 8'o121, 8'o121, 8'o121, 8'o121,
    8'o210, 8'o132, 8'o210, 8'o132, 8'o132, 8'o132, 8'o132, 8'o132
  };

  // Register shadows.
  logic       burst_en_q;
  logic       skip_en_q;
  logic [7:0] bank_modes_q;
  logic [7:0] seg_q [4];

  // Line cache shadow.
  logic [31:0] line_buf;
  logic [15:0] line_tag;
  logic        line_stale;

  fetch_result_t expected_results [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // An operand that lies past the cached word pulls in the following word.
  function automatic void cross_line(inout int lane, inout int cyc,
                                     input logic [31:0] word_b);
    if (lane > 3) begin
      line_tag = line_tag + 16'd4;
      line_buf = word_b;
      lane     = 0;
      cyc++;
    end
  endfunction

  function automatic fetch_result_t predict_fetch(input logic [15:0] pc,
                                                  input logic [31:0] word_a,
                                                  input logic [31:0] word_b);
    fetch_result_t r;
    logic [1:0]    mode;
    logic [7:0]    attr;
    logic [63:0]   pair;
    logic [31:0]   phys;
    int            lane;
    int            cyc;
    int            nops;
    r    = '0;
    cyc  = 0;
    lane = int'(pc[1:0]);
    mode = bank_modes_q[pc[15:14]*2 +: 2];
    if (burst_en_q && mode == BANK_MODE_BURST) begin
      if ((pc & 16'hfffc) != line_tag || line_stale) begin
        line_buf = word_a;
        cyc++;
      end
      line_tag     = pc & 16'hfffc;
      r.opcode     = line_buf[lane*8 +: 8];
      attr         = OPCODE_ATTR[r.opcode];
      nops         = int'(attr[2:0]);
      line_stale   = attr[6];
      lane++;
      if (nops >= 1) begin
        cross_line(lane, cyc, word_b);
        r.operand_lo = line_buf[lane*8 +: 8];
        lane++;
        if (nops >= 2) begin
          cross_line(lane, cyc, word_b);
          r.operand_hi = line_buf[lane*8 +: 8];
        end
      end
    end else begin
      // Plain fetch reads both words, keeps the cached word, marks it stale.
      line_stale   = 1'b1;
      pair         = {word_b, word_a};
      r.opcode     = pair[lane*8 +: 8];
      r.operand_lo = pair[lane*8+8 +: 8];
      attr         = OPCODE_ATTR[r.opcode];
      cyc          = 1;
      if (!(attr[7] && skip_en_q))
        cyc++;
      if (attr[2:0] == OPS_TWO || r.opcode == OPC_JSR) begin
        r.operand_hi = pair[lane*8+16 +: 8];
        cyc++;
      end
    end
    r.cycles  = cyc[1:0];
    phys      = ({24'd0, seg_q[pc[15:14]]} << 14) + {18'd0, pc[13:0]};
    phys      = phys & ((32'd1 << PHYS_ADDR_BITS_DEF) - 32'd1);
    r.phys_pc = phys[20:0];
    return r;
  endfunction

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  always @(posedge clk) begin
    fetch_result_t want;
    reg_idx_t      ridx;
    if (rst) begin
      burst_en_q   = 1'b0;
      skip_en_q    = 1'b0;
      bank_modes_q = 8'd0;
      seg_q        = '{default: 8'd0};
      line_buf     = 32'd0;
      line_tag     = 16'd0;
      line_stale   = 1'b0;
      expected_results.delete();
      in_flight <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        ridx = reg_idx_t'(paddr[4:2]);
        case (ridx)
          REG_BURST_EN:   burst_en_q   = pwdata[0];
          REG_SKIP_EN:    skip_en_q    = pwdata[0];
          REG_BANK_MODES: bank_modes_q = pwdata[7:0];
          REG_SEG0:       seg_q[0]     = pwdata[7:0];
          REG_SEG1:       seg_q[1]     = pwdata[7:0];
          REG_SEG2:       seg_q[2]     = pwdata[7:0];
          REG_SEG3:       seg_q[3]     = pwdata[7:0];
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with no fetch outstanding",
                          m_tdata[31:0], 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[7:0] !== want.opcode)
            report_mismatch("opcode_byte", 32'(m_tdata[7:0]), 32'(want.opcode));
          if (m_tdata[15:8] !== want.operand_lo)
            report_mismatch("operand_low", 32'(m_tdata[15:8]), 32'(want.operand_lo));
          if (m_tdata[23:16] !== want.operand_hi)
            report_mismatch("operand_high", 32'(m_tdata[23:16]), 32'(want.operand_hi));
          if (m_tdata[25:24] !== want.cycles)
            report_mismatch("cycles_used", 32'(m_tdata[25:24]), 32'(want.cycles));
          if (m_tdata[46:26] !== want.phys_pc)
            report_mismatch("mapped_pc", 32'(m_tdata[46:26]), 32'(want.phys_pc));
          if (m_tdata[47] !== 1'b0)
            report_mismatch("tdata pad bit", 32'(m_tdata[47]), 32'd0);
        end
      end

      if (s_tvalid && s_tready)
        expected_results.push_back(predict_fetch(s_tdata[15:0], s_tdata[47:16],
                                                 s_tdata[79:48]));
      in_flight <= expected_results.size();
    end
  end

endmodule

### tb/tb_burst_opcode_fetch_unit.sv
`timescale 1ns / 100ps

module tb_burst_opcode_fetch_unit;
  import bofu_pkg::*;

  typedef enum {RX_FREE, RX_RANDOM, RX_SPARSE} rx_pattern_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [79:0] s_tdata  = '0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr  = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;

  logic                     s_tready;
  logic                     m_tvalid;
  logic [47:0]              m_tdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  int mismatches;
  int in_flight;
  int stall_req = 0;
  int burst_left = 1;

  logic [7:0] code_mem [65536];

  burst_opcode_fetch_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  fetch_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Result side: switches between stall patterns, and serves a long
  // hold-off whenever the stimulus asks for one.
  initial begin
    rx_pattern_t pattern;
    int          span;
    int          hold_left;
    int          holds_served;
    int          tick;
    pattern      = RX_FREE;
    span         = 0;
    hold_left    = 0;
    holds_served = 0;
    tick         = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (holds_served != stall_req) begin
        holds_served = stall_req;
        hold_left    = 59;
        m_tready    <= 1'b0;
      end else begin
        if (span == 0) begin
          pattern = rx_pattern_t'($urandom_range(0, 2));
          span    = $urandom_range(20, 120);
        end
        span--;
        case (pattern)
          RX_FREE:   m_tready <= 1'b1;
          RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
          default:   m_tready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  task automatic write_reg(input reg_idx_t ridx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {ridx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offers one fetch and waits for its transaction. Fetches go out in
  // bursts separated by random gaps, some of them zero.
  task automatic send_fetch(input logic [15:0] pc, input logic [31:0] word_a,
                            input logic [31:0] word_b);
    int gap;
    s_tdata  <= {word_b, word_a, pc};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    burst_left--;
    if (burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering and waits until every expected result has come out.
  task automatic drain_fetches();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] mem_word(input logic [15:0] addr);
    logic [15:0] a0, a1, a2, a3;
    a0 = addr;
    a1 = addr + 16'd1;
    a2 = addr + 16'd2;
    a3 = addr + 16'd3;
    return {code_mem[a3], code_mem[a2], code_mem[a1], code_mem[a0]};
  endfunction

  function automatic logic [7:0] pick_segment();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [15:0] pc;
    logic [15:0] line;
    logic [7:0]  modes;
    logic [1:0]  bank_mode;
    bit          noisy;
    int          count;
    int          run_len;
    for (int i = 0; i < 65536; i++)
      code_mem[i] = 8'($urandom_range(0, 255));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: plain fetch, no skip, all segments zero.
    send_fetch(16'h0000, 32'h0403_0200, 32'h0807_0605);
    send_fetch(16'hffff, 32'hffff_ffff, 32'hffff_ffff);
    send_fetch(16'h4002, 32'h1220_0000, 32'h0000_00ab);
    send_fetch(16'h8003, 32'h0c00_0000, 32'hbbaa_5555);
    drain_fetches();

    // Plain fetch with the skip-cycle rule and extreme segments.
    write_reg(REG_SKIP_EN, 32'd1);
    write_reg(REG_SEG0, 32'hff);
    write_reg(REG_SEG1, 32'h80);
    write_reg(REG_SEG2, 32'h01);
    write_reg(REG_SEG3, 32'h7f);
    send_fetch(16'h0000, 32'h0000_0000, 32'h0000_0000);
    send_fetch(16'hc001, 32'h0000_0a00, 32'h1234_5678);
    send_fetch(16'h4002, 32'h1220_0000, 32'h0000_00cd);
    send_fetch(16'h8003, 32'hea00_0000, 32'h9988_7766);
    send_fetch(16'h3fff, 32'h0c00_0000, 32'hffee_ddcc);
    drain_fetches();

    // Burst on; banks 0..3 set to modes 1, 0, 2 and 3.
    write_reg(REG_BURST_EN, 32'd1);
    write_reg(REG_SKIP_EN, 32'd0);
    write_reg(REG_BANK_MODES, 32'he1);
    write_reg(REG_SEG0, 32'h00);
    write_reg(REG_SEG1, 32'h7f);
    write_reg(REG_SEG2, 32'h80);
    write_reg(REG_SEG3, 32'hff);
    // Reload after the plain fetches, then a hit that ignores word A,
    // then operands that run past the cached word.
    send_fetch(16'h0001, 32'h00ab_0911, 32'h0000_0000);
    send_fetch(16'h0003, 32'hdead_beef, 32'h0000_0000);
    send_fetch(16'h0003, 32'h0c00_0000, 32'h4433_2211);
    send_fetch(16'h0006, 32'h770c_0000, 32'h6655_4433);
    send_fetch(16'h4005, 32'h0000_2000, 32'h0000_0000);
    send_fetch(16'h8000, 32'h0000_000c, 32'h0000_0000);
    send_fetch(16'hc001, 32'h0000_2000, 32'h0000_0000);
    drain_fetches();

    // All banks in burst mode; the line address wraps past the top.
    write_reg(REG_BANK_MODES, 32'h55);
    write_reg(REG_SEG0, 32'hff);
    write_reg(REG_SEG1, 32'hff);
    write_reg(REG_SEG2, 32'hff);
    send_fetch(16'hffff, 32'h0900_0000, 32'h5566_7788);
    send_fetch(16'h0001, 32'hffff_ffff, 32'h0000_0000);
    send_fetch(16'h7fff, 32'h0900_0000, 32'h0102_0304);
    send_fetch(16'hbffe, 32'h000c_0000, 32'ha5a5_5a5a);

    for (int phase = 0; phase < 8; phase++) begin
      drain_fetches();
      modes = 8'd0;
      for (int b = 0; b < 4; b++) begin
        bank_mode = ($urandom_range(0, 2) != 0) ? BANK_MODE_BURST
                                                : 2'($urandom_range(0, 3));
        modes[b*2 +: 2] = bank_mode;
      end
      write_reg(REG_BURST_EN, ($urandom_range(0, 4) != 0) ? 32'd1 : 32'd0);
      write_reg(REG_SKIP_EN, 32'($urandom_range(0, 1)));
      write_reg(REG_BANK_MODES, {24'd0, modes});
      write_reg(REG_SEG0, {24'd0, pick_segment()});
      write_reg(REG_SEG1, {24'd0, pick_segment()});
      write_reg(REG_SEG2, {24'd0, pick_segment()});
      write_reg(REG_SEG3, {24'd0, pick_segment()});

      count = 0;
      while (count < 80) begin
        case ($urandom_range(0, 3))
          0:       pc = 16'hfff8 + 16'($urandom_range(0, 7));
          1:       pc = 16'h3ffc + 16'($urandom_range(0, 3)) * 16'h4000
                        + 16'($urandom_range(0, 7));
          default: pc = 16'($urandom_range(0, 65535));
        endcase
        run_len = $urandom_range(1, 12);
        // Most runs walk through consistent memory; some carry junk words.
        noisy = ($urandom_range(0, 7) == 0);
        for (int k = 0; k < run_len && count < 80; k++) begin
          line = pc & 16'hfffc;
          if (noisy)
            send_fetch(pc, $urandom, $urandom);
          else
            send_fetch(pc, mem_word(line), mem_word(line + 16'd4));
          count++;
          if ((phase == 2 || phase == 5) && count == 5)
            stall_req <= stall_req + 1;
          case ($urandom_range(0, 7))
            0:       ;
            1:       pc = 16'($urandom_range(0, 65535));
            default: pc = pc + 16'($urandom_range(1, 3));
          endcase
        end
      end
    end

    drain_fetches();
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/bofu_pkg.sv
design/bofu_cfg.sv
design/burst_opcode_fetch_unit.sv
tb/fetch_checker.sv
tb/tb_burst_opcode_fetch_unit.sv
